@@ hdl/spoa_pkg.sv @@
// spoa_pkg: constants, types and command/status codes for the page allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package spoa_pkg;
  localparam int NumPages  = 1024;
  localparam int NumOwners = 8;
  localparam int MaxAlign  = 10;
  localparam int PageW     = $clog2(NumPages);
  localparam int CountW    = PageW + 1;
  localparam int WordW     = 2 * NumOwners;

  typedef enum logic [2:0] {
    CMD_ALLOC  = 3'd0,
    CMD_ASSIGN = 3'd1,
    CMD_FREE   = 3'd2,
    CMD_QUERY  = 3'd3,
    CMD_SIZE   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_OWNER  = 3'd1,
    ST_BAD_SIZE   = 3'd2,
    ST_NO_SPACE   = 3'd3,
    ST_RANGE      = 3'd4,
    ST_RESTRICTED = 3'd5,
    ST_NOT_OWNER  = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD0, S_CHK0, S_SCAN, S_WRITE,
    S_BACK, S_BACKCHK, S_WALK, S_WALKCHK, S_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [3:0]        owner;
    logic [PageW-1:0]  page_number;
    logic [CountW-1:0] page_total;
    logic [3:0]        align_log2;
    logic [PageW-1:0]  align_phase;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [PageW-1:0]  result_page;
    logic [CountW-1:0] result_count;
    logic              answer;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic             rd;         // read table at addr
    logic [PageW-1:0] rd_addr;
    logic             wr;
    logic [PageW-1:0] wr_addr;
    logic [WordW-1:0] wr_data;
    logic             clr_wr;     // write reset value during clear pass
  } dp_cmd_t;
endpackage
`default_nettype wire

@@ hdl/spoa_if.sv @@
// spoa_if: valid/ready channel carrying a request or response payload
// depends on spoa_pkg
`timescale 1ns / 1ps
`default_nettype none
interface spoa_req_if;
  logic valid;
  logic ready;
  spoa_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface spoa_rsp_if;
  logic valid;
  logic ready;
  spoa_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/spoa_table.sv @@
// spoa_table: page table memory, one word per page, registered read
// depends on spoa_pkg
`timescale 1ns / 1ps
`default_nettype none
module spoa_table (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [spoa_pkg::PageW-1:0]   waddr_i,
  input  wire logic [spoa_pkg::WordW-1:0]   wdata_i,
  input  wire logic [spoa_pkg::PageW-1:0]   raddr_i,
  output logic      [spoa_pkg::WordW-1:0]   rdata_o
);
  logic [spoa_pkg::WordW-1:0] mem [spoa_pkg::NumPages];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

@@ hdl/spoa_ctrl.sv @@
// spoa_ctrl: sequencer for clear pass, alloc scan/write, run walks and checks
// depends on spoa_pkg; reads table data returned by the datapath memory
`timescale 1ns / 1ps
`default_nettype none
module spoa_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         req_valid_i,
  output logic                              req_ready_o,
  input  wire spoa_pkg::req_t               req_i,
  output logic                              rsp_valid_o,
  input  wire logic                         rsp_ready_i,
  output spoa_pkg::rsp_t                    rsp_o,
  input  wire logic [spoa_pkg::WordW-1:0]   rdata_i,
  output spoa_pkg::dp_cmd_t                 cmd_o
);
  localparam int PW = spoa_pkg::PageW;
  localparam int CW = spoa_pkg::CountW;
  localparam int WW = spoa_pkg::WordW;
  localparam int NO = spoa_pkg::NumOwners;

  spoa_pkg::state_e state_q, state_d;
  spoa_pkg::req_t   rq_q, rq_d;
  spoa_pkg::rsp_t   rs_q, rs_d;
  logic [CW-1:0] i_q, i_d;      // current page (may reach NumPages)
  logic [CW-1:0] s_q, s_d;      // run start
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] end_q, end_d;  // exclusive end
  logic [PW-1:0] blk_m_q, blk_m_d;  // block mask
  logic [PW-1:0] off_q, off_d;
  logic          rv_q, rv_d;

  logic [NO-1:0] own_oh;
  logic [WW-1:0] ob, lb;
  logic          owner_ok;
  logic [CW:0]   nxt_al;
  logic [CW:0]   base;
  logic [3:0]    al;

  always_comb begin
    own_oh = '0;
    if (rq_q.owner < 4'(NO)) own_oh[rq_q.owner[$clog2(NO > 1 ? NO : 2)-1:0]] = 1'b1;
    ob = {{NO{1'b0}}, own_oh};
    lb = {own_oh, {NO{1'b0}}};
    owner_ok = rq_q.owner < 4'(NO);
    // next aligned start at or after i_q + 1
    base = {1'b0, i_q} + (CW + 1)'(1);
    nxt_al = (base & ~{{(CW+1-PW){1'b0}}, blk_m_q}) + {{(CW+1-PW){1'b0}}, off_q};
    if (nxt_al < base) nxt_al = nxt_al + {{(CW+1-PW){1'b0}}, blk_m_q} + (CW + 1)'(1);
    al = (req_i.align_log2 > 4'(spoa_pkg::MaxAlign)) ? 4'(spoa_pkg::MaxAlign)
                                                       : req_i.align_log2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spoa_pkg::S_CLEAR;
      i_q     <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rq_q <= rq_d; rs_q <= rs_d; s_q <= s_d; cnt_q <= cnt_d;
    end_q <= end_d; blk_m_q <= blk_m_d; off_q <= off_d;
  end

  always_comb begin
    state_d = state_q; rq_d = rq_q; rs_d = rs_q; i_d = i_q; s_d = s_q;
    cnt_d = cnt_q; end_d = end_q; blk_m_d = blk_m_q; off_d = off_q; rv_d = rv_q;
    cmd_o = '0;
    req_ready_o = 1'b0;
    if (rv_q && rsp_ready_i) rv_d = 1'b0;
    case (state_q)
      spoa_pkg::S_CLEAR: begin
        cmd_o.wr = 1'b1;
        cmd_o.wr_addr = i_q[PW-1:0];
        cmd_o.wr_data = (i_q == '0) ? WW'({1'b1, {(NO-1){1'b0}}, 1'b1}) : '0;
        cmd_o.clr_wr = 1'b1;
        i_d = i_q + CW'(1);
        if (i_q == CW'(spoa_pkg::NumPages - 1)) state_d = spoa_pkg::S_IDLE;
      end
      spoa_pkg::S_IDLE: begin
        req_ready_o = !rv_q;
        if (req_valid_i && !rv_q) begin
          rq_d = req_i;
          rs_d = '0;
          blk_m_d = PW'((1 << al) - 1);
          off_d = req_i.align_phase & PW'((1 << al) - 1);
          state_d = spoa_pkg::S_DONE;
          case (req_i.cmd)
            spoa_pkg::CMD_ALLOC: begin
              if (req_i.page_total == '0 ||
                  req_i.page_total > CW'(spoa_pkg::NumPages))
                rs_d.status = spoa_pkg::ST_BAD_SIZE;
              else if (req_i.owner >= 4'(NO)) rs_d.status = spoa_pkg::ST_BAD_OWNER;
              else begin
                s_d = CW'(req_i.align_phase & PW'((1 << al) - 1));
                i_d = s_d; cnt_d = '0;
                state_d = spoa_pkg::S_SCAN;
                cmd_o.rd = 1'b1; cmd_o.rd_addr = s_d[PW-1:0];
                if (s_d >= CW'(spoa_pkg::NumPages))
                  begin rs_d.status = spoa_pkg::ST_NO_SPACE; state_d = spoa_pkg::S_DONE; end
              end
            end
            spoa_pkg::CMD_ASSIGN, spoa_pkg::CMD_FREE, spoa_pkg::CMD_QUERY,
            spoa_pkg::CMD_SIZE: begin
              i_d = CW'(req_i.page_number);
              cmd_o.rd = 1'b1; cmd_o.rd_addr = req_i.page_number;
              state_d = spoa_pkg::S_RD0;
            end
            default: rs_d.status = spoa_pkg::ST_RESTRICTED;
          endcase
        end
      end
      spoa_pkg::S_RD0: begin
        // keep the first page addressed so its word is on rdata next cycle
        cmd_o.rd = 1'b1; cmd_o.rd_addr = i_q[PW-1:0];
        state_d = spoa_pkg::S_CHK0;
      end
      spoa_pkg::S_CHK0: begin
        state_d = spoa_pkg::S_DONE;
        case (rq_q.cmd)
          spoa_pkg::CMD_ASSIGN: begin
            end_d = CW'({1'b0, rq_q.page_number} + rq_q.page_total);
            if (!owner_ok) rs_d.status = spoa_pkg::ST_BAD_OWNER;
            else if (rq_q.page_total == '0 ||
                     rq_q.page_total > CW'(spoa_pkg::NumPages))
              rs_d.status = spoa_pkg::ST_BAD_SIZE;
            else if ((CW + 1)'(rq_q.page_number) + (CW + 1)'(rq_q.page_total)
                     > (CW + 1)'(spoa_pkg::NumPages))
              rs_d.status = spoa_pkg::ST_RANGE;
            else if (rq_q.page_number == '0) rs_d.status = spoa_pkg::ST_RESTRICTED;
            else if (rdata_i == '0) rs_d.status = spoa_pkg::ST_RANGE;
            else if ((rdata_i & ob) == '0) begin
              i_d = CW'(rq_q.page_number);
              cmd_o.rd = 1'b1; cmd_o.rd_addr = rq_q.page_number;
              state_d = spoa_pkg::S_WRITE;
            end
          end
          spoa_pkg::CMD_QUERY: begin
            end_d = CW'({1'b0, rq_q.page_number} + rq_q.page_total);
            if (!owner_ok) rs_d.status = spoa_pkg::ST_BAD_OWNER;
            else if (rq_q.page_number == '0) rs_d.status = spoa_pkg::ST_RESTRICTED;
            else if ((CW + 1)'(rq_q.page_number) + (CW + 1)'(rq_q.page_total)
                     > (CW + 1)'(spoa_pkg::NumPages))
              rs_d.status = spoa_pkg::ST_RANGE;
            else if (rq_q.page_total == '0) rs_d.answer = 1'b1;
            else begin
              rs_d.answer = 1'b1;
              // reuse walk: checks owner bit page by page
              cmd_o.rd = 1'b1; cmd_o.rd_addr = rq_q.page_number;
              state_d = spoa_pkg::S_WALK;
            end
          end
          default: begin  // free and get size
            if (!owner_ok) rs_d.status = spoa_pkg::ST_BAD_OWNER;
            else if (rdata_i == '0) rs_d.status = spoa_pkg::ST_RANGE;
            else if (i_q == '0) rs_d.status = spoa_pkg::ST_RESTRICTED;
            else begin
              cmd_o.rd = 1'b1; cmd_o.rd_addr = i_q[PW-1:0] - PW'(1);
              state_d = spoa_pkg::S_BACK;
            end
          end
        endcase
      end
      spoa_pkg::S_SCAN: begin
        // rdata_i is page i_q
        if (rdata_i == '0) begin
          cnt_d = cnt_q + CW'(1);
          if (cnt_q + CW'(1) >= rq_q.page_total) begin
            i_d = s_q;
            cmd_o.rd = 1'b1; cmd_o.rd_addr = s_q[PW-1:0];
            state_d = spoa_pkg::S_WRITE;
          end else begin
            i_d = i_q + CW'(1);
            cmd_o.rd = 1'b1; cmd_o.rd_addr = i_d[PW-1:0];
            if (i_d >= CW'(spoa_pkg::NumPages)) begin
              rs_d.status = spoa_pkg::ST_NO_SPACE; state_d = spoa_pkg::S_DONE;
            end
          end
        end else begin
          cnt_d = '0;
          s_d = CW'(nxt_al); i_d = CW'(nxt_al);
          cmd_o.rd = 1'b1; cmd_o.rd_addr = nxt_al[PW-1:0];
          if (nxt_al >= (CW + 1)'(spoa_pkg::NumPages)) begin
            rs_d.status = spoa_pkg::ST_NO_SPACE; state_d = spoa_pkg::S_DONE;
          end
        end
      end
      spoa_pkg::S_WRITE: begin
        // rdata_i is page i_q; alloc overwrites, assign ors in
        cmd_o.wr = 1'b1; cmd_o.wr_addr = i_q[PW-1:0];
        if (rq_q.cmd == spoa_pkg::CMD_ALLOC) begin
          cmd_o.wr_data = ob;
          if (i_q + CW'(1) == s_q + rq_q.page_total) begin
            cmd_o.wr_data = ob | lb;
            rs_d.result_page = s_q[PW-1:0];
            rs_d.result_count = rq_q.page_total;
            state_d = spoa_pkg::S_DONE;
          end
        end else begin
          cmd_o.wr_data = rdata_i | ob;
          if (i_q + CW'(1) == end_q) begin
            cmd_o.wr_data = rdata_i | ob | lb;
            state_d = spoa_pkg::S_DONE;
          end
        end
        i_d = i_q + CW'(1);
        cmd_o.rd = 1'b1; cmd_o.rd_addr = i_d[PW-1:0];
        if (state_d == spoa_pkg::S_WRITE) state_d = spoa_pkg::S_RD0;
        if (state_d == spoa_pkg::S_RD0) state_d = spoa_pkg::S_WALKCHK;
      end
      spoa_pkg::S_WALKCHK: begin
        // idle state so the next read sees the word just written
        cmd_o.rd = 1'b1; cmd_o.rd_addr = i_q[PW-1:0];
        state_d = spoa_pkg::S_WRITE;
      end
      spoa_pkg::S_BACK: begin
        // rdata_i is page i_q - 1
        if ((rdata_i & ob) == '0 || (rdata_i & lb) != '0 || i_q == CW'(1)) begin
          if ((rdata_i & ob) != '0 && (rdata_i & lb) == '0) i_d = '0;
          state_d = spoa_pkg::S_BACKCHK;
          cmd_o.rd = 1'b1; cmd_o.rd_addr = i_d[PW-1:0];
        end else begin
          i_d = i_q - CW'(1);
          cmd_o.rd = 1'b1; cmd_o.rd_addr = i_d[PW-1:0] - PW'(1);
        end
      end
      spoa_pkg::S_BACKCHK: begin
        // rdata_i is run start page i_q
        s_d = i_q;
        cnt_d = '0;
        if (i_q == '0) begin
          rs_d.status = spoa_pkg::ST_RESTRICTED; state_d = spoa_pkg::S_DONE;
        end else if (rq_q.cmd == spoa_pkg::CMD_FREE && (rdata_i & ob) == '0) begin
          rs_d.status = spoa_pkg::ST_NOT_OWNER; state_d = spoa_pkg::S_DONE;
        end else begin
          rs_d.result_page = (rq_q.cmd == spoa_pkg::CMD_FREE) ? i_q[PW-1:0] : '0;
          cmd_o.rd = 1'b1; cmd_o.rd_addr = i_q[PW-1:0];
          state_d = spoa_pkg::S_WALK;
        end
      end
      spoa_pkg::S_WALK: begin
        // rdata_i is page i_q
        cmd_o.rd = 1'b1;
        i_d = i_q + CW'(1);
        cmd_o.rd_addr = i_d[PW-1:0];
        if (rq_q.cmd == spoa_pkg::CMD_QUERY) begin
          if ((rdata_i & ob) == '0) begin
            rs_d.answer = 1'b0; state_d = spoa_pkg::S_DONE;
          end else if (i_d == end_q) state_d = spoa_pkg::S_DONE;
        end else begin
          if (rq_q.cmd == spoa_pkg::CMD_FREE) begin
            cmd_o.wr = 1'b1; cmd_o.wr_addr = i_q[PW-1:0];
            cmd_o.wr_data = rdata_i & ~ob & ~lb;
            if ((rdata_i & lb) == '0) cmd_o.wr_data = rdata_i & ~ob;
          end else rs_d.result_count = rs_q.result_count + CW'(1);
          if ((rdata_i & lb) != '0 || i_d == CW'(spoa_pkg::NumPages))
            state_d = spoa_pkg::S_DONE;
        end
      end
      spoa_pkg::S_DONE: begin
        if (!rv_q) begin
          rv_d = 1'b1;
          state_d = spoa_pkg::S_IDLE;
        end
      end
      default: state_d = spoa_pkg::S_IDLE;
    endcase
  end

  assign rsp_valid_o = rv_q;
  assign rsp_o = rs_q;
endmodule
`default_nettype wire

@@ hdl/spoa_dp.sv @@
// spoa_dp: datapath holding the page table memory, driven by controller commands
// depends on spoa_pkg, spoa_table
`timescale 1ns / 1ps
`default_nettype none
module spoa_dp (
  input  wire logic                         clk_i,
  input  wire spoa_pkg::dp_cmd_t            cmd_i,
  output logic      [spoa_pkg::WordW-1:0]   rdata_o
);
  logic [spoa_pkg::WordW-1:0] raw;
  logic                       byp_q;
  logic [spoa_pkg::WordW-1:0] byp_data_q;

  spoa_table u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr),
    .waddr_i (cmd_i.wr_addr),
    .wdata_i (cmd_i.wr_data),
    .raddr_i (cmd_i.rd_addr),
    .rdata_o (raw)
  );

  // write-to-read forwarding when both hit the same page in one cycle
  always_ff @(posedge clk_i) begin
    byp_q      <= cmd_i.wr && cmd_i.rd && !cmd_i.clr_wr && (cmd_i.wr_addr == cmd_i.rd_addr);
    byp_data_q <= cmd_i.wr_data;
  end

  assign rdata_o = byp_q ? byp_data_q : raw;
endmodule
`default_nettype wire

@@ hdl/shared_page_ownership_allocator.sv @@
// shared_page_ownership_allocator: top level of the first-fit page allocator
// depends on spoa_pkg, spoa_if, spoa_ctrl, spoa_dp
//
//  channel | dir | payload                                        | handshake
//  req     | in  | cmd owner page_number page_total align_*       | valid/ready
//  rsp     | out | status result_page result_count answer         | valid/ready
//
// one request at a time; the table is a single-port-read memory, one page per cycle
// alloc: scans pages from the aligned start, then writes each page of the run found
// free, get size: walk back to the run's first page, then forward to its last page
// query, assign: checks first, then query reads and assign rewrites each page of the range
// reset runs a clearing pass over every page during which no request is taken
// the response register holds a result while the sink stalls
`timescale 1ns / 1ps
`default_nettype none
module shared_page_ownership_allocator (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  spoa_req_if.sink   req,
  spoa_rsp_if.source rsp
);
  spoa_pkg::dp_cmd_t          dp_cmd;
  logic [spoa_pkg::WordW-1:0] rdata;

  // sequencer: decode, checks, scans and walks
  spoa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .req_i       (req.data),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .rsp_o       (rsp.data),
    .rdata_i     (rdata),
    .cmd_o       (dp_cmd)
  );

  // page table storage
  spoa_dp u_dp (
    .clk_i   (clk_i),
    .cmd_i   (dp_cmd),
    .rdata_o (rdata)
  );
endmodule
`default_nettype wire

@@ hdl/spoa_checker.sv @@
// spoa_checker: port-level assertions for the page allocator, bound to the top
// depends on spoa_pkg, spoa_if
`timescale 1ns / 1ps
`default_nettype none
module spoa_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic req_valid_i,
  input wire logic req_ready_i,
  input wire logic rsp_valid_i,
  input wire logic rsp_ready_i,
  input wire spoa_pkg::rsp_t rsp_data_i
);
  // a held response keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_data_i))
    else $error("rsp payload changed while stalled");
  // no new request taken while a response waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !req_ready_i)
    else $error("request accepted while response pending");
  // a response never comes in the cycle right after acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !rsp_valid_i)
    else $error("response too early");
  // status codes stay in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_data_i.status <= spoa_pkg::ST_NOT_OWNER)
    else $error("bad status code");
  // failed requests report no page
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.status != spoa_pkg::ST_OK |-> rsp_data_i.result_page == '0)
    else $error("page on failure");
endmodule

bind shared_page_ownership_allocator spoa_checker u_spoa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req.valid),
  .req_ready_i (req.ready),
  .rsp_valid_i (rsp.valid),
  .rsp_ready_i (rsp.ready),
  .rsp_data_i  (rsp.data)
);
`default_nettype wire

@@ dv/tb.sv @@
// tb: self-checking testbench for the shared page ownership allocator
// depends on spoa_pkg, spoa_if and the shared_page_ownership_allocator rtl
// requests are mirrored by a page table model held in a scoreboard class
`timescale 1ns / 1ps
`default_nettype none

// page table mirror and queue of pending responses
class page_owner_board;
  logic [spoa_pkg::WordW-1:0] pages [spoa_pkg::NumPages];
  spoa_pkg::rsp_t pending [$];
  int errors;

  function new();
    errors = 0;
    for (int i = 0; i < spoa_pkg::NumPages; i++) pages[i] = '0;
    pages[0][0] = 1'b1;
    pages[0][spoa_pkg::NumOwners] = 1'b1;
  endfunction

  // walk back to the first page of the owner's run
  function int run_head(int pn, int o);
    int p;
    p = pn;
    while (p > 0) begin
      if (!pages[p-1][o] || pages[p-1][spoa_pkg::NumOwners+o]) break;
      p--;
    end
    return p;
  endfunction

  function int next_start(int x, int blk, int off);
    int s;
    s = (x & ~(blk - 1)) + off;
    if (s < x) s += blk;
    return s;
  endfunction

  // compute the response of one accepted request and update the mirror
  function void note_request(spoa_pkg::req_t r);
    spoa_pkg::rsp_t e;
    int o, pn, n, al, blk, off, s, i, cnt, lb;
    e = '0;
    o = int'(r.owner); pn = int'(r.page_number); n = int'(r.page_total);
    al = int'(r.align_log2); lb = spoa_pkg::NumOwners + o;
    e.status = spoa_pkg::ST_OK;
    case (r.cmd)
      spoa_pkg::CMD_ALLOC: begin
        if (n == 0 || n > spoa_pkg::NumPages) e.status = spoa_pkg::ST_BAD_SIZE;
        else if (o >= spoa_pkg::NumOwners) e.status = spoa_pkg::ST_BAD_OWNER;
        else begin
          if (al > spoa_pkg::MaxAlign) al = spoa_pkg::MaxAlign;
          blk = 1 << al;
          off = int'(r.align_phase) & (blk - 1);
          s = next_start(0, blk, off);
          i = s; cnt = 0;
          while (i < spoa_pkg::NumPages) begin
            if (pages[i] == '0) begin
              cnt++;
              if (cnt >= n) break;
              i++;
            end else begin
              cnt = 0;
              s = next_start(i + 1, blk, off);
              i = s;
            end
          end
          if (s >= spoa_pkg::NumPages || cnt < n) e.status = spoa_pkg::ST_NO_SPACE;
          else begin
            for (i = s; i < s + n; i++) begin
              pages[i] = '0;
              pages[i][o] = 1'b1;
            end
            pages[s+n-1][lb] = 1'b1;
            e.result_page = s[spoa_pkg::PageW-1:0];
            e.result_count = n[spoa_pkg::CountW-1:0];
          end
        end
      end
      spoa_pkg::CMD_ASSIGN: begin
        if (o >= spoa_pkg::NumOwners) e.status = spoa_pkg::ST_BAD_OWNER;
        else if (n == 0 || n > spoa_pkg::NumPages) e.status = spoa_pkg::ST_BAD_SIZE;
        else if (pn + n - 1 >= spoa_pkg::NumPages) e.status = spoa_pkg::ST_RANGE;
        else if (pn == 0) e.status = spoa_pkg::ST_RESTRICTED;
        else if (pages[pn] == '0) e.status = spoa_pkg::ST_RANGE;
        else if (!pages[pn][o]) begin
          for (i = pn; i < pn + n; i++) pages[i][o] = 1'b1;
          pages[pn+n-1][lb] = 1'b1;
        end
      end
      spoa_pkg::CMD_FREE: begin
        if (o >= spoa_pkg::NumOwners) e.status = spoa_pkg::ST_BAD_OWNER;
        else if (pages[pn] == '0) e.status = spoa_pkg::ST_RANGE;
        else begin
          s = run_head(pn, o);
          if (s == 0) e.status = spoa_pkg::ST_RESTRICTED;
          else if (!pages[s][o]) e.status = spoa_pkg::ST_NOT_OWNER;
          else begin
            for (i = s; i < spoa_pkg::NumPages; i++) begin
              pages[i][o] = 1'b0;
              if (pages[i][lb]) begin
                pages[i][lb] = 1'b0;
                break;
              end
            end
            e.result_page = s[spoa_pkg::PageW-1:0];
          end
        end
      end
      spoa_pkg::CMD_QUERY: begin
        if (o >= spoa_pkg::NumOwners) e.status = spoa_pkg::ST_BAD_OWNER;
        else if (pn == 0) e.status = spoa_pkg::ST_RESTRICTED;
        else if (pn + n > spoa_pkg::NumPages) e.status = spoa_pkg::ST_RANGE;
        else begin
          e.answer = 1'b1;
          for (i = pn; i < pn + n; i++)
            if (!pages[i][o]) begin
              e.answer = 1'b0;
              break;
            end
        end
      end
      spoa_pkg::CMD_SIZE: begin
        if (o >= spoa_pkg::NumOwners) e.status = spoa_pkg::ST_BAD_OWNER;
        else if (pages[pn] == '0) e.status = spoa_pkg::ST_RANGE;
        else begin
          s = run_head(pn, o);
          if (s == 0) e.status = spoa_pkg::ST_RESTRICTED;
          else begin
            cnt = 0;
            for (i = s; i < spoa_pkg::NumPages; i++) begin
              cnt++;
              if (pages[i][lb]) break;
            end
            e.result_count = cnt[spoa_pkg::CountW-1:0];
          end
        end
      end
      default: e.status = spoa_pkg::ST_RESTRICTED;
    endcase
    pending.push_back(e);
  endfunction

  function void check_response(spoa_pkg::rsp_t a);
    spoa_pkg::rsp_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected response, expected none, actual %h", $time, a);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (a.status !== e.status) begin
      $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
      errors++;
    end
    if (a.result_page !== e.result_page) begin
      $display("%0t: result_page expected %0d actual %0d", $time, e.result_page,
               a.result_page);
      errors++;
    end
    if (a.result_count !== e.result_count) begin
      $display("%0t: result_count expected %0d actual %0d", $time, e.result_count,
               a.result_count);
      errors++;
    end
    if (a.answer !== e.answer) begin
      $display("%0t: answer expected %0d actual %0d", $time, e.answer, a.answer);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int StallLimit = 40000;   // idle cycles allowed

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  spoa_req_if req ();
  spoa_rsp_if rsp ();

  shared_page_ownership_allocator dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req.sink),
    .rsp   (rsp.source)
  );

  always #5 clk_i = ~clk_i;

  page_owner_board board;
  bit  send_done;
  bit  calm;          // no idling on either side
  bit  hold_rsp;      // long receiver hold-off requested
  bit  hold_done;     // hold-off already served
  int  quiet_cycles;

  initial begin
    req.valid = 1'b0;
    req.data  = '0;
    rsp.ready = 1'b0;
  end

  // one request: optional idle gap, then hold valid until accepted
  task automatic send_request(spoa_pkg::req_t r);
    while (!calm && $urandom_range(99) < 28) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.data  <= r;
    do @(posedge clk_i); while (!req.ready);
    board.note_request(r);
  endtask

  function automatic spoa_pkg::req_t make_req(spoa_pkg::cmd_e c, int o, int pn, int n,
                                              int al, int aoff);
    spoa_pkg::req_t r;
    r.cmd = c; r.owner = o[3:0]; r.page_number = pn[spoa_pkg::PageW-1:0];
    r.page_total = n[spoa_pkg::CountW-1:0];
    r.align_log2 = al[3:0]; r.align_phase = aoff[spoa_pkg::PageW-1:0];
    return r;
  endfunction

  // random request, mostly well-formed and aimed at live runs
  function automatic spoa_pkg::req_t random_req();
    spoa_pkg::req_t r;
    int k, pn, o, al, ph, n;
    k = $urandom_range(99);
    o = ($urandom_range(9) == 0) ? $urandom_range(15)
                                 : $urandom_range(spoa_pkg::NumOwners-1);
    al = ($urandom_range(3) == 0) ? $urandom_range(15) : 0;
    ph = $urandom_range(1023);
    n = ($urandom_range(19) == 0) ? $urandom_range(2047) : $urandom_range(1, 24);
    r.owner = o[3:0];
    r.align_log2 = al[3:0];
    r.align_phase = ph[spoa_pkg::PageW-1:0];
    r.page_total = n[spoa_pkg::CountW-1:0];
    // pick a page that is likely allocated
    pn = $urandom_range(1023);
    for (int t = 0; t < 8; t++) begin
      if (board.pages[pn] != '0) break;
      pn = $urandom_range(1, 200);
    end
    r.page_number = pn[spoa_pkg::PageW-1:0];
    if (k < 35)      r.cmd = spoa_pkg::CMD_ALLOC;
    else if (k < 50) r.cmd = spoa_pkg::CMD_ASSIGN;
    else if (k < 75) r.cmd = spoa_pkg::CMD_FREE;
    else if (k < 85) r.cmd = spoa_pkg::CMD_QUERY;
    else if (k < 96) r.cmd = spoa_pkg::CMD_SIZE;
    else             r.cmd = spoa_pkg::cmd_e'($urandom_range(5, 7));
    return r;
  endfunction

  // stimulus
  initial begin
    board = new();
    calm = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: size and owner checks, alignment, fault page, unknown codes
    send_request(make_req(spoa_pkg::CMD_ALLOC, 0, 0, 0, 0, 0));
    send_request(make_req(spoa_pkg::CMD_ALLOC, 9, 0, 4, 0, 0));
    send_request(make_req(spoa_pkg::CMD_ALLOC, 1, 0, 1025, 0, 0));
    send_request(make_req(spoa_pkg::CMD_ALLOC, 1, 0, 3, 0, 0));
    send_request(make_req(spoa_pkg::CMD_ALLOC, 2, 0, 5, 4, 3));
    send_request(make_req(spoa_pkg::CMD_ALLOC, 3, 0, 2, 15, 1023));
    send_request(make_req(spoa_pkg::CMD_ALLOC, 4, 0, 1024, 0, 0));
    send_request(make_req(spoa_pkg::CMD_ASSIGN, 5, 2, 2, 0, 0));
    send_request(make_req(spoa_pkg::CMD_ASSIGN, 1, 1, 3, 0, 0));
    send_request(make_req(spoa_pkg::CMD_ASSIGN, 5, 0, 1, 0, 0));
    send_request(make_req(spoa_pkg::CMD_ASSIGN, 5, 1000, 100, 0, 0));
    send_request(make_req(spoa_pkg::CMD_ASSIGN, 5, 500, 1, 0, 0));
    send_request(make_req(spoa_pkg::CMD_ASSIGN, 15, 1, 1, 0, 0));
    send_request(make_req(spoa_pkg::CMD_ASSIGN, 5, 1, 0, 0, 0));
    send_request(make_req(spoa_pkg::CMD_QUERY, 5, 1, 0, 0, 0));
    send_request(make_req(spoa_pkg::CMD_QUERY, 1, 1, 3, 0, 0));
    send_request(make_req(spoa_pkg::CMD_QUERY, 1, 0, 3, 0, 0));
    send_request(make_req(spoa_pkg::CMD_QUERY, 1, 1023, 2, 0, 0));
    send_request(make_req(spoa_pkg::CMD_SIZE, 1, 3, 0, 0, 0));
    send_request(make_req(spoa_pkg::CMD_SIZE, 0, 0, 0, 0, 0));
    send_request(make_req(spoa_pkg::CMD_FREE, 6, 2, 0, 0, 0));
    send_request(make_req(spoa_pkg::CMD_FREE, 0, 0, 0, 0, 0));
    send_request(make_req(spoa_pkg::CMD_FREE, 1, 2, 0, 0, 0));
    send_request(make_req(spoa_pkg::CMD_FREE, 1, 600, 0, 0, 0));
    send_request(make_req(spoa_pkg::cmd_e'(3'd7), 0, 0, 0, 0, 0));
    // random part, with a calm stretch and one long receiver hold-off
    for (int i = 0; i < 290; i++) begin
      calm = (i >= 100 && i < 150);
      if (i == 200) hold_rsp = 1'b1;
      send_request(random_req());
    end
    req.valid <= 1'b0;
    send_done = 1'b1;
  end

  // response side
  initial begin
    forever begin
      @(posedge clk_i);
      if (rsp.valid && rsp.ready) board.check_response(rsp.data);
      if (hold_rsp && !hold_done) begin
        rsp.ready <= 1'b0;
        repeat (200) @(posedge clk_i);
        if (rsp.valid && rsp.ready) board.check_response(rsp.data);
        hold_done = 1'b1;
      end
      rsp.ready <= calm || ($urandom_range(99) >= 28);
    end
  end

  // watchdog and end of run
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("shared_page_ownership_allocator verification failed");
        $finish;
      end
      if (send_done && board != null && board.pending.size() == 0) begin
        repeat (100) @(posedge clk_i);
        if (board.errors == 0 && board.pending.size() == 0)
          $display("shared_page_ownership_allocator verification clean");
        else
          $display("shared_page_ownership_allocator verification failed");
        $finish;
      end
    end
  end
endmodule
`default_nettype wire
